// ===== design/bcpn_pkg.sv =====
// Shared constants and types for the box closest-point and normal block.
package bcpn_pkg;

   // Default coordinate width: signed Q16.16
   localparam int COORD_WIDTH_DEF = 32;

   // Configuration register index width and register indexes
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LOWER_X = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LOWER_Y = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LOWER_Z = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UPPER_X = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UPPER_Y = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UPPER_Z = 3'd5;

   // Reset corners: lower 0.0, upper 1.0 in Q16.16 (truncated to the coordinate width)
   localparam logic [63:0] LOWER_RESET = 64'd0;
   localparam logic [63:0] UPPER_RESET = 64'd65536;

   // Face normal codes, in tie-break priority order
   localparam int FACE_WIDTH = 3;

   typedef enum logic [FACE_WIDTH-1:0] {
      FACE_POS_X = 3'd0,
      FACE_POS_Y = 3'd1,
      FACE_POS_Z = 3'd2,
      FACE_NEG_X = 3'd3,
      FACE_NEG_Y = 3'd4,
      FACE_NEG_Z = 3'd5
   } face_type;

   localparam face_type POS_FACE [3] = '{FACE_POS_X, FACE_POS_Y, FACE_POS_Z};
   localparam face_type NEG_FACE [3] = '{FACE_NEG_X, FACE_NEG_Y, FACE_NEG_Z};

endpackage

// ===== design/bcpn_req_if.sv =====
// Query point channel: valid/ready handshake with three signed coordinates.
interface bcpn_req_if import bcpn_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] query_x;
   logic signed [COORD_WIDTH-1:0] query_y;
   logic signed [COORD_WIDTH-1:0] query_z;

   modport source (output valid, output query_x, output query_y, output query_z,
                   input ready);
   modport sink   (input valid, input query_x, input query_y, input query_z,
                   output ready);
endinterface

// ===== design/bcpn_rsp_if.sv =====
// Result channel: valid/ready handshake with surface point, face normal and inside flag.
interface bcpn_rsp_if import bcpn_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] near_x;
   logic signed [COORD_WIDTH-1:0] near_y;
   logic signed [COORD_WIDTH-1:0] near_z;
   logic [FACE_WIDTH-1:0]         face_normal;
   logic                          was_inside;

   modport source (output valid, output near_x, output near_y, output near_z,
                   output face_normal, output was_inside, input ready);
   modport sink   (input valid, input near_x, input near_y, input near_z,
                   input face_normal, input was_inside, output ready);
endinterface

// ===== design/box_closest_point_and_normal_core.sv =====
// Closest point on an axis-aligned box surface and the outward normal of its face.
//
//   channel  | direction | handshake        | payload
//   ---------+-----------+------------------+-------------------------------------------
//   req_ch   | in        | valid / ready    | query_x, query_y, query_z
//   rsp_ch   | out       | valid / ready    | near_x, near_y, near_z, face_normal,
//            |           |                  | was_inside
//   csr_*    | in        | csr_we, no wait  | csr_index, csr_wdata (box corners)
//
// One point per cycle sustained while rsp_ch.ready is high; a point passes the query register,
// then the result register, before rsp valid rises. The face search is one compare tree
// between those two registers.
// Reset (synchronous) empties both stages and restores the unit box [0,1]^3.
// A stalled result holds in the result register while the query register still takes one
// more point; req_ch.ready drops only when both are full and rsp_ch.ready is low.
module box_closest_point_and_normal_core import bcpn_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   bcpn_req_if.sink                   req_ch,
   bcpn_rsp_if.source                 rsp_ch,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COORD_WIDTH-1:0]     csr_wdata
);

   // Offsets and distances need one bit more than a coordinate
   localparam int OW = COORD_WIDTH + 1;

   localparam logic [COORD_WIDTH-1:0] LOWER_RST = COORD_WIDTH'(LOWER_RESET);
   localparam logic [COORD_WIDTH-1:0] UPPER_RST = COORD_WIDTH'(UPPER_RESET);

   // Box corners
   logic signed [COORD_WIDTH-1:0] lo_ff [3];
   logic signed [COORD_WIDTH-1:0] hi_ff [3];

   // Query stage
   logic                          s1_valid_ff;
   logic signed [COORD_WIDTH-1:0] q_ff [3];

   // Result stage
   logic                          s2_valid_ff;
   logic signed [COORD_WIDTH-1:0] near_ff [3];
   face_type                      face_ff;
   logic                          inside_ff;

   // Handshake
   logic req_xfer;
   logic s2_load;

   // Datapath
   logic                          axis_in   [3];
   logic                          inside_in;
   logic signed [COORD_WIDTH-1:0] clamp_lo  [3];
   logic signed [COORD_WIDTH-1:0] clamp_c   [3];
   logic signed [OW-1:0]          key       [6];
   logic signed [OW-1:0]          win01_key, win23_key, win45_key, win03_key;
   face_type                      win01_face, win23_face, win45_face, win03_face;
   face_type                      face_in;
   logic signed [COORD_WIDTH-1:0] near_in   [3];

   // ------------------------------------------------------------------
   // Flow control: the result stage loads when empty or when its transfer
   // completes; the query stage takes a point when empty or when it can pass its own on.
   // ------------------------------------------------------------------
   assign s2_load      = !s2_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || s2_load;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   // ------------------------------------------------------------------
   // Configuration registers; out-of-range indexes drop the write.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            lo_ff[a] <= LOWER_RST;
            hi_ff[a] <= UPPER_RST;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            REG_LOWER_X: lo_ff[0] <= csr_wdata;
            REG_LOWER_Y: lo_ff[1] <= csr_wdata;
            REG_LOWER_Z: lo_ff[2] <= csr_wdata;
            REG_UPPER_X: hi_ff[0] <= csr_wdata;
            REG_UPPER_Y: hi_ff[1] <= csr_wdata;
            REG_UPPER_Z: hi_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Query register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         q_ff[0] <= req_ch.query_x;
         q_ff[1] <= req_ch.query_y;
         q_ff[2] <= req_ch.query_z;
      end
   end

   // ------------------------------------------------------------------
   // Face search. Both cases reduce to "largest key, first face wins":
   //   inside:  key = -distance to face  (hi - q for +faces, q - lo for -faces)
   //   outside: key = dot(offset, normal) = +/- (q - clamped)
   // ------------------------------------------------------------------
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         axis_in[a]  = (q_ff[a] >= lo_ff[a]) && (q_ff[a] <= hi_ff[a]);
         // Raise to lower bound first, then cap at upper bound (inverted box gives upper)
         clamp_lo[a] = (q_ff[a] < lo_ff[a]) ? lo_ff[a] : q_ff[a];
         clamp_c[a]  = (clamp_lo[a] > hi_ff[a]) ? hi_ff[a] : clamp_lo[a];
      end
      inside_in = axis_in[0] && axis_in[1] && axis_in[2];

      for (int a = 0; a < 3; a++) begin
         if (inside_in) begin
            key[a]     = OW'(q_ff[a]) - OW'(hi_ff[a]);
            key[a + 3] = OW'(lo_ff[a]) - OW'(q_ff[a]);
         end else begin
            key[a]     = OW'(q_ff[a]) - OW'(clamp_c[a]);
            key[a + 3] = OW'(clamp_c[a]) - OW'(q_ff[a]);
         end
      end

      // Left operand has the lower face index: replace only on strictly greater
      if (key[1] > key[0]) begin
         win01_key = key[1]; win01_face = FACE_POS_Y;
      end else begin
         win01_key = key[0]; win01_face = FACE_POS_X;
      end
      if (key[3] > key[2]) begin
         win23_key = key[3]; win23_face = FACE_NEG_X;
      end else begin
         win23_key = key[2]; win23_face = FACE_POS_Z;
      end
      if (key[5] > key[4]) begin
         win45_key = key[5]; win45_face = FACE_NEG_Z;
      end else begin
         win45_key = key[4]; win45_face = FACE_NEG_Y;
      end
      if (win23_key > win01_key) begin
         win03_key = win23_key; win03_face = win23_face;
      end else begin
         win03_key = win01_key; win03_face = win01_face;
      end
      face_in = (win45_key > win03_key) ? win45_face : win03_face;

      // Inside: snap the chosen axis to its face. Outside: clamped point.
      for (int a = 0; a < 3; a++) begin
         if (!inside_in) begin
            near_in[a] = clamp_c[a];
         end else if (face_in == POS_FACE[a]) begin
            near_in[a] = hi_ff[a];
         end else if (face_in == NEG_FACE[a]) begin
            near_in[a] = lo_ff[a];
         end else begin
            near_in[a] = q_ff[a];
         end
      end
   end

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_load) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load && s1_valid_ff) begin
         near_ff   <= near_in;
         face_ff   <= face_in;
         inside_ff <= inside_in;
      end
   end

   assign rsp_ch.valid       = s2_valid_ff;
   assign rsp_ch.near_x      = near_ff[0];
   assign rsp_ch.near_y      = near_ff[1];
   assign rsp_ch.near_z      = near_ff[2];
   assign rsp_ch.face_normal = face_ff;
   assign rsp_ch.was_inside  = inside_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(s2_valid_ff) |-> $past(s1_valid_ff))
      else $error("result became valid without a held query");

   a_query_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_load) |=> (s1_valid_ff && $stable(q_ff[0]) &&
                                     $stable(q_ff[1]) && $stable(q_ff[2])))
      else $error("stalled query was lost or overwritten");

   a_inside_snaps_to_face: assert property (@(posedge clock) disable iff (reset)
      (s2_load && s1_valid_ff && inside_in && face_in == FACE_POS_X) |=>
         (rsp_ch.near_x == $past(hi_ff[0]) && rsp_ch.was_inside))
      else $error("inside point not snapped to the +x face");

   a_outside_within_box: assert property (@(posedge clock) disable iff (reset)
      (s2_load && s1_valid_ff && !inside_in && lo_ff[1] <= hi_ff[1]) |=>
         (rsp_ch.near_y >= $past(lo_ff[1]) && rsp_ch.near_y <= $past(hi_ff[1])))
      else $error("clamped y left the box");

endmodule
